// ===== sv/svn_pkg.sv =====
// Package for the smoothed vertex normal block: command codes, sequencer
// states, fixed field widths and default sizes. No dependencies.
`default_nettype none
package svn_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned POS_BITS_DEF     = 24;
  localparam int unsigned ACC_BITS_DEF     = 24;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned FPOS_W     = 24;
  localparam int unsigned NRM_W      = 16;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned NUM_W      = 45;
  localparam int unsigned TOP_BIT    = 29;
  localparam int unsigned UNIT_ONE   = 16384;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } svn_cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TRI_RA, S_TRI_RB, S_TRI_RC, S_TRI_RD, S_MUL, S_RD_WAIT,
    S_LOAD, S_SHIFT, S_SQ, S_SQRT, S_DIV_LD, S_DIV, S_ACC_RD, S_ACC_WR, S_OUT
  } svn_state_e;

endpackage
`default_nettype wire

// ===== sv/smooth_vertex_normals.sv =====
// Smoothed vertex normal block: position store, normal accumulators and a
// sequencer around one shared multiplier, root and divider datapath.
// Depends on svn_pkg.
//
// Requests enter on s_axis (tuser = command), results leave on m_axis.
// Write vertex is stored in the cycle it is accepted. Add triangle reads
// three corners, runs six products on the multiplier, a normalizing shift
// of one bit per cycle, three squares, a 31-step square root and three
// divisions, then three accumulator updates. Read vertex normal runs the
// shift, squares, root and divisions on the stored accumulator.
// Clear accumulators sweeps the accumulator memory, one entry per cycle;
// the same sweep runs after reset. s_axis_tready is high only while idle.
// The result sits in an output register; a new request is taken while it
// waits, and a following read holds in its last step until the register
// is free. A stalled receiver stalls nothing else.
`default_nettype none
module smooth_vertex_normals #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MAX_VERTICES_DEF,
  parameter int unsigned POS_BITS     = svn_pkg::POS_BITS_DEF,
  parameter int unsigned ACC_BITS     = svn_pkg::ACC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  wire logic [svn_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_vertex, normal_x, normal_y, normal_z, zero pad
  output logic [svn_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // no_normal
  output logic [0:0]                            m_axis_tuser
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int SH = (POS_BITS > 24) ? POS_BITS - 24 : 0;
  localparam int DW = (POS_BITS > 24) ? 25 : POS_BITS + 1;
  localparam int CW = 2 * DW + 1;
  localparam int VW = (CW > ACC_BITS) ? CW : ACC_BITS;
  localparam int NW = (VW > 30) ? VW : 30;
  localparam int QN = svn_pkg::NUM_W - svn_pkg::LEN_W;
  localparam int Q_W_LOC = svn_pkg::Q_W;

  function automatic logic [IW-1:0] to_addr(logic [svn_pkg::IDX_W-1:0] v);
    logic [IW+svn_pkg::IDX_W-1:0] e;
    e = (IW + svn_pkg::IDX_W)'(v);
    return e[IW-1:0];
  endfunction

  function automatic logic in_rng(logic [svn_pkg::IDX_W-1:0] v);
    return 32'(v) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic signed [DW-1:0] pdiff(logic signed [POS_BITS-1:0] p,
                                                 logic signed [POS_BITS-1:0] q);
    logic signed [POS_BITS:0] d;
    d = (POS_BITS + 1)'(p) - (POS_BITS + 1)'(q);
    return DW'(d >>> SH);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_add(
      logic signed [ACC_BITS-1:0] a, logic signed [svn_pkg::NRM_W-1:0] n);
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS + 1)'(a) + (ACC_BITS + 1)'(n);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return s[ACC_BITS-1:0];
  endfunction

  svn_pkg::svn_state_e state_q, state_d;

  logic [3*POS_BITS-1:0] pos_mem [MAX_VERTICES];
  logic [3*ACC_BITS-1:0] acc_mem [MAX_VERTICES];
  logic [3*POS_BITS-1:0] pos_rd_q;
  logic [3*ACC_BITS-1:0] acc_rd_q;
  logic [IW-1:0]         pos_raddr, acc_raddr, acc_waddr;
  logic                  acc_we;
  logic [3*ACC_BITS-1:0] acc_wdata;

  logic [IW-1:0] clr_q;
  logic          m_valid_q;
  logic [2:0]    cnt_q;
  logic [3:0]    bcnt_q;
  logic          is_read_q, zflag_q;
  logic [svn_pkg::IDX_W-1:0] vi_q, ca_q, cb_q, cc_q, corner;

  logic signed [POS_BITS-1:0] pa_q [3];
  logic signed [DW-1:0]       u_q [3];
  logic signed [DW-1:0]       w_q [3];
  logic signed [CW-1:0]       cross_q [3];
  logic [NW-1:0]              mag_q [3];
  logic                       neg_q [3];
  logic signed [svn_pkg::NRM_W-1:0] n_q [3];

  logic signed [svn_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*svn_pkg::MUL_W-1:0] prod_q;
  logic [svn_pkg::SQ_W-1:0]  len2_q, x_q, r_q, bit_q, sq_t;
  logic [svn_pkg::NUM_W-1:0] num_q, dvs_q;
  logic [Q_W_LOC-1:0]        q_q;

  logic [svn_pkg::IDX_W-1:0] in_vi, in_ca, in_cb, in_cc;
  logic signed [svn_pkg::FPOS_W-1:0] in_px, in_py, in_pz;
  svn_pkg::svn_cmd_e in_cmd;
  logic accept;

  logic signed [VW-1:0] src [3];
  logic [NW-1:0]        absv [3];
  logic                 src_zero;
  logic [NW-1:0]        orm;
  logic                 sh_right, sh_left, sq_ge, div_ge, out_load;
  logic [Q_W_LOC-1:0]   q_fin, q_cap;
  logic [1:0]           ci;

  assign in_vi  = s_axis_tdata[9:0];
  assign in_px  = s_axis_tdata[33:10];
  assign in_py  = s_axis_tdata[57:34];
  assign in_pz  = s_axis_tdata[81:58];
  assign in_ca  = s_axis_tdata[91:82];
  assign in_cb  = s_axis_tdata[101:92];
  assign in_cc  = s_axis_tdata[111:102];
  assign in_cmd = svn_pkg::svn_cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == svn_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ci            = cnt_q[1:0];

  always_comb begin
    case (ci)
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (is_read_q) src[i] = VW'($signed(acc_rd_q[ACC_BITS*i +: ACC_BITS]));
      else           src[i] = VW'(cross_q[i]);
      absv[i] = src[i][VW-1] ? NW'(VW'(-src[i])) : NW'(VW'(src[i]));
    end
    src_zero = (src[0] == '0) && (src[1] == '0) && (src[2] == '0);
    orm      = mag_q[0] | mag_q[1] | mag_q[2];
    sh_right = |(orm >> 30);
    sh_left  = !sh_right && !orm[svn_pkg::TOP_BIT];
    sq_t     = r_q + bit_q;
    sq_ge    = (x_q >= sq_t);
    div_ge   = (num_q >= dvs_q);
    q_fin    = {q_q[Q_W_LOC-2:0], div_ge};
    q_cap    = (q_fin > Q_W_LOC'(svn_pkg::UNIT_ONE)) ? Q_W_LOC'(svn_pkg::UNIT_ONE) : q_fin;
    out_load = (state_q == svn_pkg::S_OUT) && (!m_valid_q || m_axis_tready);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == svn_pkg::S_MUL) begin
      case (cnt_q)
        3'd0: begin mul_a = svn_pkg::MUL_W'(u_q[1]); mul_b = svn_pkg::MUL_W'(w_q[2]); end
        3'd1: begin mul_a = svn_pkg::MUL_W'(u_q[2]); mul_b = svn_pkg::MUL_W'(w_q[1]); end
        3'd2: begin mul_a = svn_pkg::MUL_W'(u_q[2]); mul_b = svn_pkg::MUL_W'(w_q[0]); end
        3'd3: begin mul_a = svn_pkg::MUL_W'(u_q[0]); mul_b = svn_pkg::MUL_W'(w_q[2]); end
        3'd4: begin mul_a = svn_pkg::MUL_W'(u_q[0]); mul_b = svn_pkg::MUL_W'(w_q[1]); end
        3'd5: begin mul_a = svn_pkg::MUL_W'(u_q[1]); mul_b = svn_pkg::MUL_W'(w_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == svn_pkg::S_SQ && cnt_q < 3'd3) begin
      mul_a = $signed({2'b00, mag_q[ci][29:0]});
      mul_b = $signed({2'b00, mag_q[ci][29:0]});
    end
  end

  always_comb begin
    case (state_q)
      svn_pkg::S_TRI_RA: pos_raddr = to_addr(ca_q);
      svn_pkg::S_TRI_RB: pos_raddr = to_addr(cb_q);
      default:           pos_raddr = to_addr(cc_q);
    endcase
    acc_raddr = (state_q == svn_pkg::S_RD_WAIT) ? to_addr(vi_q) : to_addr(corner);
    acc_we    = 1'b0;
    acc_waddr = to_addr(corner);
    acc_wdata = '0;
    if (state_q == svn_pkg::S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_q;
    end else if (state_q == svn_pkg::S_ACC_WR) begin
      acc_we = 1'b1;
      for (int i = 0; i < 3; i++) begin
        acc_wdata[ACC_BITS*i +: ACC_BITS] =
          sat_add($signed(acc_rd_q[ACC_BITS*i +: ACC_BITS]), n_q[i]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      svn_pkg::S_CLEAR:
        if (clr_q == IW'(MAX_VERTICES - 1)) state_d = svn_pkg::S_IDLE;
      svn_pkg::S_IDLE:
        if (accept) begin
          case (in_cmd)
            svn_pkg::CMD_TRI:
              if (in_rng(in_ca) && in_rng(in_cb) && in_rng(in_cc)) state_d = svn_pkg::S_TRI_RA;
            svn_pkg::CMD_READ:
              state_d = in_rng(in_vi) ? svn_pkg::S_RD_WAIT : svn_pkg::S_OUT;
            svn_pkg::CMD_CLEAR: state_d = svn_pkg::S_CLEAR;
            default:            state_d = svn_pkg::S_IDLE;
          endcase
        end
      svn_pkg::S_TRI_RA:  state_d = svn_pkg::S_TRI_RB;
      svn_pkg::S_TRI_RB:  state_d = svn_pkg::S_TRI_RC;
      svn_pkg::S_TRI_RC:  state_d = svn_pkg::S_TRI_RD;
      svn_pkg::S_TRI_RD:  state_d = svn_pkg::S_MUL;
      svn_pkg::S_MUL:     if (cnt_q == 3'd6) state_d = svn_pkg::S_LOAD;
      svn_pkg::S_RD_WAIT: state_d = svn_pkg::S_LOAD;
      svn_pkg::S_LOAD:
        if (src_zero) state_d = is_read_q ? svn_pkg::S_OUT : svn_pkg::S_IDLE;
        else          state_d = svn_pkg::S_SHIFT;
      svn_pkg::S_SHIFT:   if (!sh_right && !sh_left) state_d = svn_pkg::S_SQ;
      svn_pkg::S_SQ:      if (cnt_q == 3'd3) state_d = svn_pkg::S_SQRT;
      svn_pkg::S_SQRT:    if (bit_q[0]) state_d = svn_pkg::S_DIV_LD;
      svn_pkg::S_DIV_LD:  state_d = svn_pkg::S_DIV;
      svn_pkg::S_DIV:
        if (bcnt_q == 4'd0) begin
          if (ci != 2'd2)     state_d = svn_pkg::S_DIV_LD;
          else if (is_read_q) state_d = svn_pkg::S_OUT;
          else                state_d = svn_pkg::S_ACC_RD;
        end
      svn_pkg::S_ACC_RD:  state_d = svn_pkg::S_ACC_WR;
      svn_pkg::S_ACC_WR:  state_d = (ci == 2'd2) ? svn_pkg::S_IDLE : svn_pkg::S_ACC_RD;
      svn_pkg::S_OUT:     if (out_load) state_d = svn_pkg::S_IDLE;
      default:            state_d = svn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= svn_pkg::S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == svn_pkg::S_CLEAR)           clr_q <= clr_q + IW'(1);
      else                                       clr_q <= '0;
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_cmd == svn_pkg::CMD_WRITE && in_rng(in_vi)) begin
      pos_mem[to_addr(in_vi)] <= {POS_BITS'(in_pz), POS_BITS'(in_py), POS_BITS'(in_px)};
    end
    pos_rd_q <= pos_mem[pos_raddr];
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_q <= acc_mem[acc_raddr];
  end

  logic [svn_pkg::IDX_W-1:0]        out_vi_q;
  logic signed [svn_pkg::NRM_W-1:0] out_n_q [3];
  logic                             out_nn_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      svn_pkg::S_IDLE: begin
        vi_q      <= in_vi;
        ca_q      <= in_ca;
        cb_q      <= in_cb;
        cc_q      <= in_cc;
        is_read_q <= (in_cmd == svn_pkg::CMD_READ);
        zflag_q   <= !in_rng(in_vi);
      end
      svn_pkg::S_TRI_RB:
        for (int i = 0; i < 3; i++) pa_q[i] <= $signed(pos_rd_q[POS_BITS*i +: POS_BITS]);
      svn_pkg::S_TRI_RC:
        for (int i = 0; i < 3; i++) begin
          u_q[i] <= pdiff($signed(pos_rd_q[POS_BITS*i +: POS_BITS]), pa_q[i]);
        end
      svn_pkg::S_TRI_RD: begin
        for (int i = 0; i < 3; i++) begin
          w_q[i] <= pdiff($signed(pos_rd_q[POS_BITS*i +: POS_BITS]), pa_q[i]);
        end
        cnt_q <= '0;
      end
      svn_pkg::S_MUL: begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q != 3'd0) begin
          if (cnt_q[0]) cross_q[2'((cnt_q - 3'd1) >> 1)] <= CW'(prod_q);
          else cross_q[2'((cnt_q - 3'd1) >> 1)] <=
                 cross_q[2'((cnt_q - 3'd1) >> 1)] - CW'(prod_q);
        end
      end
      svn_pkg::S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= absv[i];
          neg_q[i] <= src[i][VW-1];
        end
        zflag_q <= src_zero;
        cnt_q   <= '0;
        len2_q  <= '0;
      end
      svn_pkg::S_SHIFT:
        for (int i = 0; i < 3; i++) begin
          if (sh_right)     mag_q[i] <= mag_q[i] >> 1;
          else if (sh_left) mag_q[i] <= mag_q[i] << 1;
        end
      svn_pkg::S_SQ: begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q != 3'd0) len2_q <= len2_q + prod_q[svn_pkg::SQ_W-1:0];
        x_q   <= len2_q + prod_q[svn_pkg::SQ_W-1:0];
        r_q   <= '0;
        bit_q <= svn_pkg::SQ_W'(1) << 60;
      end
      svn_pkg::S_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - sq_t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) cnt_q <= '0;
      end
      svn_pkg::S_DIV_LD: begin
        num_q  <= svn_pkg::NUM_W'({mag_q[ci][29:0], 14'b0})
                + svn_pkg::NUM_W'(r_q[svn_pkg::LEN_W-1:1]);
        dvs_q  <= {r_q[svn_pkg::LEN_W-1:0], QN'(0)};
        bcnt_q <= 4'd14;
        q_q    <= '0;
      end
      svn_pkg::S_DIV: begin
        if (div_ge) num_q <= num_q - dvs_q;
        dvs_q  <= dvs_q >> 1;
        q_q    <= q_fin;
        bcnt_q <= bcnt_q - 4'd1;
        if (bcnt_q == 4'd0) begin
          n_q[ci] <= neg_q[ci] ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
          cnt_q   <= (ci == 2'd2) ? 3'd0 : cnt_q + 3'd1;
        end
      end
      svn_pkg::S_ACC_WR: cnt_q <= cnt_q + 3'd1;
      default: ;
    endcase
    if (out_load) begin
      out_vi_q <= vi_q;
      out_nn_q <= zflag_q;
      for (int i = 0; i < 3; i++) out_n_q[i] <= zflag_q ? '0 : n_q[i];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, out_n_q[2], out_n_q[1], out_n_q[0], out_vi_q};
  assign m_axis_tuser  = out_nn_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == svn_pkg::S_OUT))
    else $error("result raised outside the output step");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[25:10]) <= 16384)
                   && ($signed(m_axis_tdata[25:10]) >= -16384)
                   && ($signed(m_axis_tdata[41:26]) <= 16384)
                   && ($signed(m_axis_tdata[41:26]) >= -16384)
                   && ($signed(m_axis_tdata[57:42]) <= 16384)
                   && ($signed(m_axis_tdata[57:42]) >= -16384))
    else $error("normal component out of unit range");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[57:10] == '0))
    else $error("flagged result carries a nonzero normal");

endmodule
`default_nettype wire
